// ----- src/irt_pkg.sv -----
// shared types and constants for the interval reservation table
// no dependencies
`default_nettype none

package irt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int TIME_W              = 32;
    localparam int STATUS_W            = 2;

    localparam logic [STATUS_W-1:0] STATUS_BOOKED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERLAP = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic read;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic slot_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- src/interval_reservation_table.sv -----
// Books half-open intervals [start_time, end_time) into a table of up to TABLE_DEPTH
// non-overlapping entries; each request beat yields one status beat: booked, overlap
// or table full. After acceptance the scan reads the stored entries one per cycle
// from the single-port table memory, stopping early when an overlap is found; the
// result is then registered once an earlier result no longer waits on the output.
// The next request is taken while a result still waits on the output. The table
// starts empty after reset.
// top level; depends on irt_pkg, irt_ctrl and irt_datapath
`default_nettype none

module interval_reservation_table #(
    parameter int TABLE_DEPTH = irt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [irt_pkg::TIME_W-1:0]  start_time,
    input  wire logic [irt_pkg::TIME_W-1:0]  end_time,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [irt_pkg::STATUS_W-1:0]     status
);

    irt_pkg::dp_cmd_t    dp_cmd;
    irt_pkg::dp_status_t dp_status;

    irt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    irt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_time (start_time),
        .end_time   (end_time),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status)
    );

endmodule

`default_nettype wire

// ----- src/irt_ctrl.sv -----
// controller state machine for the interval reservation table
// depends on irt_pkg
`default_nettype none

module irt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire irt_pkg::dp_status_t dp_status,
    output irt_pkg::dp_cmd_t         dp_cmd
);

    irt_pkg::ctrl_state_t state_reg;
    irt_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= irt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            irt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = irt_pkg::ST_SCAN;
                end
            end
            irt_pkg::ST_SCAN:
            begin
                if (dp_status.scan_done)
                begin
                    state_next = irt_pkg::ST_DECIDE;
                end
            end
            irt_pkg::ST_DECIDE:
            begin
                if (dp_status.slot_free)
                begin
                    state_next = irt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = irt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        dp_cmd.start  = 1'b0;
        dp_cmd.read   = 1'b0;
        dp_cmd.finish = 1'b0;
        case (state_reg)
            irt_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                dp_cmd.start = in_valid;
            end
            irt_pkg::ST_SCAN:
            begin
                dp_cmd.read = ~dp_status.scan_done;
            end
            irt_pkg::ST_DECIDE:
            begin
                dp_cmd.finish = dp_status.slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/irt_datapath.sv -----
// interval table memory, scan pointer, overlap check and result register
// depends on irt_pkg
`default_nettype none

module irt_datapath #(
    parameter int TABLE_DEPTH = irt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [irt_pkg::TIME_W-1:0]  start_time,
    input  wire logic [irt_pkg::TIME_W-1:0]  end_time,
    input  wire irt_pkg::dp_cmd_t            dp_cmd,
    output irt_pkg::dp_status_t              dp_status,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [irt_pkg::STATUS_W-1:0]     status
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    logic [irt_pkg::TIME_W-1:0] mem_start [TABLE_DEPTH];
    logic [irt_pkg::TIME_W-1:0] mem_end   [TABLE_DEPTH];

    logic [irt_pkg::TIME_W-1:0]  req_start_reg;
    logic [irt_pkg::TIME_W-1:0]  req_end_reg;
    logic [irt_pkg::TIME_W-1:0]  rd_start_reg;
    logic [irt_pkg::TIME_W-1:0]  rd_end_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            idx_next;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        chk_valid_reg;
    logic                        chk_valid_next;
    logic                        hit_reg;
    logic                        hit_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [irt_pkg::STATUS_W-1:0] status_reg;
    logic [irt_pkg::STATUS_W-1:0] status_next;
    logic                        clash;
    logic                        book;
    logic                        rd_en;

    assign clash = chk_valid_reg && (req_end_reg > rd_start_reg) && (req_start_reg < rd_end_reg);
    assign book  = dp_cmd.finish && !hit_reg && (count_reg != DEPTH_CNT);
    assign rd_en = dp_cmd.read && (idx_reg != count_reg);

    assign dp_status.scan_done = hit_reg || ((idx_reg == count_reg) && !chk_valid_reg);
    assign dp_status.slot_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

    // request, table payload and result status
    always_ff @(posedge clk)
    begin
        if (dp_cmd.start)
        begin
            req_start_reg <= start_time;
            req_end_reg   <= end_time;
        end
        if (rd_en)
        begin
            rd_start_reg <= mem_start[idx_reg[IDX_W-1:0]];
            rd_end_reg   <= mem_end[idx_reg[IDX_W-1:0]];
        end
        if (book)
        begin
            mem_start[count_reg[IDX_W-1:0]] <= req_start_reg;
            mem_end[count_reg[IDX_W-1:0]]   <= req_end_reg;
        end
        status_reg <= status_next;
    end

    always_comb
    begin
        idx_next       = idx_reg;
        chk_valid_next = rd_en;
        hit_next       = hit_reg | clash;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        if (dp_cmd.start)
        begin
            idx_next       = '0;
            chk_valid_next = 1'b0;
            hit_next       = 1'b0;
        end
        else if (rd_en)
        begin
            idx_next = idx_reg + CNT_W'(1);
        end
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (dp_cmd.finish)
        begin
            out_valid_next = 1'b1;
            if (hit_reg)
            begin
                status_next = irt_pkg::STATUS_OVERLAP;
            end
            else if (count_reg == DEPTH_CNT)
            begin
                status_next = irt_pkg::STATUS_FULL;
            end
            else
            begin
                status_next = irt_pkg::STATUS_BOOKED;
                count_next  = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
